>>> src/hns_pkg.sv
// Shared widths, register indexes, term table and sine function of the harmonic note synthesizer.
package hns_pkg;

  // Field widths of the request, response and configuration channels.
  localparam int FREQ_W   = 22;
  localparam int IDX_W    = 24;
  localparam int AMP_W    = 16;
  localparam int SAMPLE_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int STYLE_W  = 3;
  localparam int SR_W     = 18;
  localparam int FADE_W   = 16;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_STYLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 2'd2;

  // Register reset values.
  localparam logic [STYLE_W-1:0] STYLE_RESET = 3'd4;
  localparam logic [SR_W-1:0]    SR_RESET    = 18'd44100;
  localparam logic [FADE_W-1:0]  FADE_RESET  = 16'd441;

  // Parameter defaults.
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int MAX_TERMS_DEF       = 48;

  // Datapath widths of the phase and scaling arithmetic.
  localparam int H_W      = 5;
  localparam int SCALE_W  = 17;
  localparam int OFS_W    = 11;
  localparam int WGT_W    = 14;
  localparam int FE_W     = 24;
  localparam int HFE_W    = H_W + FE_W;
  localparam int PROD_W   = HFE_W + IDX_W;
  localparam int DIV_W    = SR_W + 9;
  localparam int QD_W     = 64 - 23;
  localparam int CNT_W    = 6;
  localparam int ACC_W    = 32;
  localparam int TADDR_W  = 7;
  localparam int TCNT_W   = 6;
  localparam int NUM_TERMS = 89;

  typedef struct packed {
    logic [H_W-1:0]            h;
    logic [SCALE_W-1:0]        scale;
    logic signed [OFS_W-1:0]   offset;
    logic [WGT_W-1:0]          weight;
  } term_t;

  localparam int U1 = 65536;
  localparam int SA = 64487;
  localparam int SB = 65012;
  localparam int SC = 66060;
  localparam int SD = 66585;
  localparam int R1 = 65864;
  localparam int R2 = 65208;
  localparam int R3 = 66191;
  localparam int R4 = 64881;

  function automatic term_t tm(input int h, input int s, input int o, input int w);
    term_t r;
    r.h      = H_W'(h);
    r.scale  = SCALE_W'(s);
    r.offset = OFS_W'(o);
    r.weight = WGT_W'(w);
    return r;
  endfunction

  // Term table of all eight styles.
  localparam term_t TERMS [NUM_TERMS] = '{
    // sine
    tm(2,U1,0,256),
    // harmonic
    tm(2,U1,0,256), tm(4,U1,0,26), tm(6,U1,0,87), tm(8,U1,0,15), tm(10,U1,0,13),
    tm(12,U1,0,13),
    // low harmonic
    tm(2,U1,0,256), tm(1,U1,0,128), tm(4,U1,0,64),
    // blurred
    tm(2,U1,0,256), tm(2,U1,256,128), tm(2,U1,-256,128), tm(2,U1,512,64),
    tm(2,U1,-512,64),
    tm(4,U1,0,64), tm(4,U1,256,32), tm(4,U1,-256,32), tm(4,U1,512,16), tm(4,U1,-512,16),
    tm(1,U1,0,128), tm(1,U1,256,64), tm(1,U1,-256,64), tm(1,U1,512,32), tm(1,U1,-512,32),
    // rounded
    tm(2,U1,0,256), tm(2,R1,0,128), tm(2,R2,0,128), tm(2,R3,0,64), tm(2,R4,0,64),
    tm(4,U1,0,64), tm(4,R1,0,32), tm(4,R2,0,32), tm(4,R3,0,16), tm(4,R4,0,16),
    // bass pure
    tm(2,U1,0,1213), tm(4,U1,0,4207), tm(6,U1,0,9566), tm(8,U1,0,3985),
    tm(12,U1,0,916), tm(14,U1,0,1684), tm(16,U1,0,3121), tm(18,U1,0,908),
    // bass blended
    tm(2,SA,0,109), tm(2,SB,0,216), tm(2,U1,0,530), tm(2,SC,0,250), tm(2,SD,0,107),
    tm(4,SA,0,379), tm(4,SB,0,751), tm(4,U1,0,1840), tm(4,SC,0,867), tm(4,SD,0,370),
    tm(6,SA,0,863), tm(6,SB,0,1707), tm(6,U1,0,4184), tm(6,SC,0,1971), tm(6,SD,0,842),
    tm(8,SA,0,359), tm(8,SB,0,711), tm(8,U1,0,1743), tm(8,SC,0,821), tm(8,SD,0,351),
    tm(12,SA,0,83), tm(12,SB,0,164), tm(12,U1,0,401), tm(12,SC,0,189), tm(12,SD,0,81),
    tm(14,SA,0,152), tm(14,SB,0,301), tm(14,U1,0,737), tm(14,SC,0,347), tm(14,SD,0,148),
    tm(16,SA,0,281), tm(16,SB,0,557), tm(16,U1,0,1365), tm(16,SC,0,643), tm(16,SD,0,275),
    tm(18,SA,0,82), tm(18,SB,0,162), tm(18,U1,0,397), tm(18,SC,0,187), tm(18,SD,0,80),
    // bass second/third
    tm(2,U1,0,1491), tm(4,U1,0,12588), tm(6,U1,0,7300), tm(8,U1,0,2804),
    tm(14,U1,0,914), tm(16,U1,0,503)
  };

  localparam logic [TADDR_W-1:0] STYLE_START [8] = '{
    7'd0, 7'd1, 7'd7, 7'd10, 7'd25, 7'd35, 7'd43, 7'd83
  };
  localparam logic [TCNT_W-1:0] STYLE_COUNT [8] = '{
    6'd1, 6'd6, 6'd3, 6'd15, 6'd10, 6'd8, 6'd40, 6'd6
  };

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Quarter-wave sine in Q0.15 by a seven-term Taylor series; t runs over 0..2^qbits.
  function automatic logic [14:0] quarter_sine(input int unsigned t, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] trm;
    logic [63:0] v;
    logic signed [63:0] sum;
    x   = (PI_HALF_Q30 * 64'(t)) >> qbits;
    x2  = (x * x) >> 30;
    trm = x;
    sum = $signed(x);
    trm = ((trm * x2) >> 30) / 64'd6;
    sum = sum - $signed(trm);
    trm = ((trm * x2) >> 30) / 64'd20;
    sum = sum + $signed(trm);
    trm = ((trm * x2) >> 30) / 64'd42;
    sum = sum - $signed(trm);
    trm = ((trm * x2) >> 30) / 64'd72;
    sum = sum + $signed(trm);
    trm = ((trm * x2) >> 30) / 64'd110;
    sum = sum - $signed(trm);
    trm = ((trm * x2) >> 30) / 64'd156;
    sum = sum + $signed(trm);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 15'd32767 : v[14:0];
  endfunction

endpackage

>>> src/hns_req_if.sv
// Request channel carrying one note sample request per item.
interface hns_req_if
  import hns_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic [IDX_W-1:0]  sample_index;
  logic [IDX_W-1:0]  note_length;
  logic [AMP_W-1:0]  amplitude;

  modport source (output valid, frequency, sample_index, note_length, amplitude,
                  input ready);
  modport sink   (input valid, frequency, sample_index, note_length, amplitude,
                  output ready);
endinterface

>>> src/hns_rsp_if.sv
// Response channel carrying one synthesized sample per item.
interface hns_rsp_if
  import hns_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       saturated;

  modport source (output valid, sample_value, saturated, input ready);
  modport sink   (input valid, sample_value, saturated, output ready);
endinterface

>>> src/hns_cfg_if.sv
// Configuration write channel carrying a register index and write data.
interface hns_cfg_if
  import hns_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/harmonic_note_sample_synth_unit.sv
// Top level of the additive harmonic note sample synthesizer.
//
// Usage: each item on req (frequency, sample_index, note_length, amplitude)
// yields one item on rsp (sample_value, saturated). The cfg channel writes
// style (index 0), sample_rate (index 1) and fade_length (index 2); it is
// always ready and should be used only while no request is in flight.
// One shared 33x33 multiplier and one shared compare-subtract stage for the
// phase do the work under a sequencer, with a small divider for the fade.
// Each term of the selected style runs through four setup steps, 53
// restoring-division steps for the phase remainder, SINE_TABLE_BITS steps
// for the table index, a sine table read and an accumulate. The final
// scaling then does two multiplies, a 41-step divide by the fade length
// and the output load.
// req is ready only while the sequencer is idle. The result sits in an
// output register, so the next item is accepted while rsp stalls; the
// sequencer then waits at its last step until that register is free.
// Reset (rst, synchronous) returns the registers to style 4, sample rate
// 44100 and fade length 441, and empties the output register.
module harmonic_note_sample_synth_unit
  import hns_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int MAX_TERMS       = MAX_TERMS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  hns_cfg_if.sink  cfg,
  hns_req_if.sink  req,
  hns_rsp_if.source rsp
);

  localparam int QB     = SINE_TABLE_BITS - 2;
  localparam int QTR    = 1 << QB;
  localparam int TI_W   = SINE_TABLE_BITS - 1;
  localparam int ZB     = PHASE_BITS - SINE_TABLE_BITS;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_FSCALE = 13'b0000000000010,
    ST_FE     = 13'b0000000000100,
    ST_HFE    = 13'b0000000001000,
    ST_HFN    = 13'b0000000010000,
    ST_MOD    = 13'b0000000100000,
    ST_FRAC   = 13'b0000001000000,
    ST_SINE   = 13'b0000010000000,
    ST_MAC    = 13'b0000100000000,
    ST_FADE   = 13'b0001000000000,
    ST_SCALE  = 13'b0010000000000,
    ST_QDIV   = 13'b0100000000000,
    ST_DONE   = 13'b1000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [STYLE_W-1:0] style;
  logic [SR_W-1:0]    sample_rate;
  logic [FADE_W-1:0]  fade_length;

  // Captured request.
  logic [FREQ_W-1:0] freq;
  logic [IDX_W-1:0]  n_idx;
  logic [IDX_W-1:0]  n_len;
  logic [AMP_W-1:0]  amp;

  // Sequencer and datapath registers.
  logic [TADDR_W-1:0]          term_base;
  logic [TCNT_W-1:0]           term_k;
  logic [TCNT_W-1:0]           term_cnt;
  logic [63:0]                 prod;
  logic [FE_W-1:0]             feabs;
  logic                        feneg;
  logic [PROD_W-1:0]           psh;
  logic [DIV_W-1:0]            rem;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [CNT_W-1:0]            bit_cnt;
  logic [14:0]                 sine_mag;
  logic                        sine_neg;
  logic signed [ACC_W-1:0]     acc;
  logic [FADE_W-1:0]           den;
  logic [QD_W-1:0]             qsh;
  logic [FADE_W-1:0]           qrem;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  out_value;
  logic                        out_sat;

  // Constant quarter-wave table, read through a register.
  logic [14:0] sine_rom [0:QTR];
  for (genvar g = 0; g <= QTR; g++) begin : g_sine
    assign sine_rom[g] = quarter_sine(g, QB);
  end

  // Current term and the phase divisor.
  term_t              term;
  logic [DIV_W-1:0]   d_val;
  logic [TCNT_W-1:0]  style_cnt;
  assign term      = TERMS[7'(term_base + 7'(term_k))];
  assign d_val     = {sample_rate, 9'd0};
  assign style_cnt = (32'(STYLE_COUNT[style]) > 32'(MAX_TERMS)) ?
                     TCNT_W'(MAX_TERMS) : STYLE_COUNT[style];

  // Shared multiplier with operands selected by the sequencer.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;
  logic [ACC_W-1:0]   acc_mag;
  logic [IDX_W-1:0]   fade_num;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   near_end;
  logic [FADE_W-1:0]  num_sel;
  logic [FADE_W-1:0]  den_sel;

  assign acc_mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign tail     = n_len - n_idx;
  assign near_end = (n_idx < tail) ? n_idx : tail;

  // Fade numerator and denominator.
  always_comb begin
    fade_num = near_end;
    if (n_idx >= n_len) begin
      num_sel = '0;
      den_sel = FADE_W'(1);
    end else if (fade_length == '0 || fade_num >= IDX_W'(fade_length)) begin
      num_sel = FADE_W'(1);
      den_sel = FADE_W'(1);
    end else begin
      num_sel = fade_num[FADE_W-1:0];
      den_sel = fade_length;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FSCALE: begin
        mul_a = $signed(33'(freq));
        mul_b = $signed(33'(term.scale));
      end
      ST_HFE: begin
        mul_a = $signed(33'(term.h));
        mul_b = $signed(33'(feabs));
      end
      ST_HFN: begin
        mul_a = $signed(33'(prod[HFE_W-1:0]));
        mul_b = $signed(33'(n_idx));
      end
      ST_MAC: begin
        mul_a = $signed(33'(term.weight));
        mul_b = sine_neg ? -$signed(33'(sine_mag)) : $signed(33'(sine_mag));
      end
      ST_FADE: begin
        mul_a = $signed(33'(amp));
        mul_b = $signed(33'(num_sel));
      end
      ST_SCALE: begin
        mul_a = $signed(33'(acc_mag));
        mul_b = $signed(33'(prod[31:0]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Effective frequency from the rounded scale product plus the offset.
  logic [22:0]          fe_u;
  logic signed [FE_W:0] fe_s;
  logic [38:0]          fe_round;
  assign fe_round = prod[38:0] + 39'd32768;
  assign fe_u     = fe_round[38:16];
  assign fe_s     = $signed({2'b00, fe_u}) + (FE_W+1)'(term.offset);

  // Shared compare-subtract stage for the phase remainder and table-index steps.
  logic [DIV_W:0] r2;
  logic           r_ge;
  always_comb begin
    if (state == ST_MOD) begin
      r2 = {rem, psh[PROD_W-1]};
    end else begin
      r2 = {rem, 1'b0};
    end
    r_ge = r2 >= {1'b0, d_val};
  end

  logic [FADE_W:0] q2;
  logic            q_ge;
  assign q2   = {qrem, qsh[QD_W-1]};
  assign q_ge = q2 >= {1'b0, den};

  // Table index with negation for a negative frequency.
  logic                       low_zero;
  logic [SINE_TABLE_BITS-1:0] ph_idx;
  logic [1:0]                 quad;
  logic [TI_W-1:0]            t_addr;
  assign low_zero = {rem, {ZB{1'b0}}} < {{ZB{1'b0}}, d_val};
  always_comb begin
    if (sample_rate == '0) begin
      ph_idx = '0;
    end else if (feneg) begin
      ph_idx = ~idx + SINE_TABLE_BITS'(low_zero);
    end else begin
      ph_idx = idx;
    end
    quad = ph_idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
    if (quad[0]) begin
      t_addr = TI_W'(QTR) - {1'b0, ph_idx[QB-1:0]};
    end else begin
      t_addr = {1'b0, ph_idx[QB-1:0]};
    end
  end

  // Saturation and sign of the final quotient.
  logic [QD_W-1:0]     q_lim;
  logic                q_sat;
  logic [SAMPLE_W-1:0] q_out;
  always_comb begin
    q_lim = qsh;
    q_sat = 1'b0;
    if (!acc[ACC_W-1] && qsh > QD_W'(32'h7FFF_FFFF)) begin
      q_lim = QD_W'(32'h7FFF_FFFF);
      q_sat = 1'b1;
    end else if (acc[ACC_W-1] && qsh > QD_W'(32'h8000_0000)) begin
      q_lim = QD_W'(32'h8000_0000);
      q_sat = 1'b1;
    end
    q_out = acc[ACC_W-1] ? (32'd0 - q_lim[SAMPLE_W-1:0]) : q_lim[SAMPLE_W-1:0];
  end

  assign cfg.ready        = 1'b1;
  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.sample_value = out_value;
  assign rsp.saturated    = out_sat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      style       <= STYLE_RESET;
      sample_rate <= SR_RESET;
      fade_length <= FADE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_STYLE:       style       <= cfg.data[STYLE_W-1:0];
        CFG_SAMPLE_RATE: sample_rate <= cfg.data[SR_W-1:0];
        CFG_FADE_LENGTH: fade_length <= cfg.data[FADE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sine table read.
  always_ff @(posedge clk) begin
    if (state == ST_SINE) begin
      sine_mag <= sine_rom[t_addr];
      sine_neg <= quad[1];
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The output register empties when its item is taken, unless a new one loads.
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            freq      <= req.frequency;
            n_idx     <= req.sample_index;
            n_len     <= req.note_length;
            amp       <= req.amplitude;
            term_base <= STYLE_START[style];
            term_cnt  <= style_cnt;
            term_k    <= '0;
            acc       <= '0;
            state     <= ST_FSCALE;
          end
        end
        ST_FSCALE: begin
          prod  <= mul_p[63:0];
          state <= ST_FE;
        end
        ST_FE: begin
          feneg <= fe_s[FE_W];
          feabs <= fe_s[FE_W] ? FE_W'(-fe_s) : FE_W'(fe_s);
          state <= ST_HFE;
        end
        ST_HFE: begin
          prod  <= mul_p[63:0];
          state <= ST_HFN;
        end
        ST_HFN: begin
          psh     <= mul_p[PROD_W-1:0];
          rem     <= '0;
          bit_cnt <= CNT_W'(PROD_W - 1);
          state   <= ST_MOD;
        end
        ST_MOD: begin
          rem     <= r_ge ? DIV_W'(r2 - {1'b0, d_val}) : DIV_W'(r2);
          psh     <= {psh[PROD_W-2:0], 1'b0};
          bit_cnt <= bit_cnt - CNT_W'(1);
          if (bit_cnt == '0) begin
            bit_cnt <= CNT_W'(SINE_TABLE_BITS - 1);
            state   <= ST_FRAC;
          end
        end
        ST_FRAC: begin
          rem     <= r_ge ? DIV_W'(r2 - {1'b0, d_val}) : DIV_W'(r2);
          idx     <= {idx[SINE_TABLE_BITS-2:0], r_ge};
          bit_cnt <= bit_cnt - CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_SINE;
          end
        end
        ST_SINE: begin
          state <= ST_MAC;
        end
        ST_MAC: begin
          acc <= acc + $signed(mul_p[ACC_W-1:0]);
          if (term_k + TCNT_W'(1) == term_cnt) begin
            state <= ST_FADE;
          end else begin
            term_k <= term_k + TCNT_W'(1);
            state  <= ST_FSCALE;
          end
        end
        ST_FADE: begin
          prod  <= mul_p[63:0];
          den   <= den_sel;
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          qsh     <= mul_p[63:23];
          qrem    <= '0;
          bit_cnt <= CNT_W'(QD_W - 1);
          state   <= ST_QDIV;
        end
        ST_QDIV: begin
          qrem    <= q_ge ? FADE_W'(q2 - {1'b0, den}) : FADE_W'(q2);
          qsh     <= {qsh[QD_W-2:0], q_ge};
          bit_cnt <= bit_cnt - CNT_W'(1);
          if (bit_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_value <= $signed(q_out);
            out_sat   <= q_sat;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
